### rtl/tlpq_pkg.sv
// tlpq_pkg: shared types and constants of the three-level priority queue.
// Used by the interfaces, the controller, the datapath and the top level.
// No dependencies.
`default_nettype none

package tlpq_pkg;

    // Field widths
    localparam int ID_W       = 16;
    localparam int PRIO_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int LEVEL_W    = 2;
    localparam int ENTRY_W    = ID_W + PRIO_W;
    localparam int NUM_LEVELS = 3;

    // Default slots per queue
    localparam int QUEUE_DEPTH_DEF = 64;

    // Command codes
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ENQUEUED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DEQUEUED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    // Queue levels
    localparam logic [LEVEL_W-1:0] LVL_ONE   = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_TWO   = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_THREE = 2'd2;

    // Priorities that pick the first two queues
    localparam logic [PRIO_W-1:0] PRIO_ONE = 8'd1;
    localparam logic [PRIO_W-1:0] PRIO_TWO = 8'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // latch the input beat
        logic exec;     // run the queue operation
        logic capture;  // take RAM read data into the result
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic deq_read; // the operation needs a RAM read
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/tlpq_item_if.sv
// tlpq_item_if: input channel of the queue (valid/ready plus item fields).
// Depends on tlpq_pkg.
`default_nettype none

interface tlpq_item_if
    import tlpq_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              command;
    logic [ID_W-1:0]   in_id;
    logic [PRIO_W-1:0] in_priority;

    modport source (output valid, output command, output in_id, output in_priority,
                    input ready);
    modport sink   (input valid, input command, input in_id, input in_priority,
                    output ready);
endinterface

`default_nettype wire

### rtl/tlpq_result_if.sv
// tlpq_result_if: result channel of the queue (valid/ready plus result fields).
// Depends on tlpq_pkg.
`default_nettype none

interface tlpq_result_if
    import tlpq_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     out_id;
    logic [PRIO_W-1:0]   out_priority;
    logic [LEVEL_W-1:0]  out_level;

    modport source (output valid, output status, output out_id, output out_priority,
                    output out_level, input ready);
    modport sink   (input valid, input status, input out_id, input out_priority,
                    input out_level, output ready);
endinterface

`default_nettype wire

### rtl/three_level_priority_queue.sv
// three_level_priority_queue: strict-priority scheduler over three linear job queues.
// An input beat is latched, then EXEC runs the queue operation and registers the result;
// a dequeue hit passes READ to capture the entry RAM's registered read; OUT then presents it.
// A new beat is taken only once the result is accepted; one item in flight.
// Reset (synchronous, active low) rewinds all queues to empty; the entry RAM is not cleared.
// Depends on tlpq_pkg, tlpq_item_if, tlpq_result_if, tlpq_ctrl, tlpq_dp.
`default_nettype none

module three_level_priority_queue
    import tlpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    tlpq_item_if.sink     i_item,
    tlpq_result_if.source o_result
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer
    tlpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    // Datapath
    tlpq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_command      (i_item.command),
        .i_in_id        (i_item.in_id),
        .i_in_priority  (i_item.in_priority),
        .o_status       (o_result.status),
        .o_out_id       (o_result.out_id),
        .o_out_priority (o_result.out_priority),
        .o_out_level    (o_result.out_level)
    );

endmodule

`default_nettype wire

### rtl/tlpq_ram.sv
// tlpq_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module tlpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/tlpq_ctrl.sv
// tlpq_ctrl: sequencer of the queue; one item in flight at a time.
// Depends on tlpq_pkg.
`default_nettype none

module tlpq_ctrl
    import tlpq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_dp_cmd       o_cmd,
    input  wire t_dp_stat i_stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       in_fire;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign in_fire     = i_in_valid && o_in_ready;

    // Commands to the datapath
    always_comb begin
        o_cmd.load    = in_fire;
        o_cmd.exec    = (r_state == S_EXEC);
        o_cmd.capture = (r_state == S_READ);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_stat.deq_read ? S_READ : S_OUT;
            end
            S_READ: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### rtl/tlpq_dp.sv
// tlpq_dp: queue datapath: item register, per-queue indices, entry RAM, result register.
// Depends on tlpq_pkg and tlpq_ram.
`default_nettype none

module tlpq_dp
    import tlpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_stat               o_stat,
    input  wire logic              i_command,
    input  wire logic [ID_W-1:0]   i_in_id,
    input  wire logic [PRIO_W-1:0] i_in_priority,
    output logic [STATUS_W-1:0]    o_status,
    output logic [ID_W-1:0]        o_out_id,
    output logic [PRIO_W-1:0]      o_out_priority,
    output logic [LEVEL_W-1:0]     o_out_level
);

    localparam int IW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int RAM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
    localparam int AW        = $clog2(RAM_DEPTH);
    localparam logic [IW-1:0] IDX_LAST = IW'(QUEUE_DEPTH - 1);
    localparam logic [AW-1:0] BASE_TWO   = AW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] BASE_THREE = AW'(2 * QUEUE_DEPTH);

    // Latched item
    logic              r_command;
    logic [ID_W-1:0]   r_id;
    logic [PRIO_W-1:0] r_prio;

    // Queue indices
    logic [IW-1:0]         r_head [NUM_LEVELS];
    logic [IW-1:0]         r_tail [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] r_nonempty;
    logic [IW-1:0]         n_head [NUM_LEVELS];
    logic [IW-1:0]         n_tail [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] n_nonempty;

    // Result register
    logic [STATUS_W-1:0] r_status;
    logic [ID_W-1:0]     r_out_id;
    logic [PRIO_W-1:0]   r_out_prio;
    logic [LEVEL_W-1:0]  r_out_level;

    logic [LEVEL_W-1:0] enq_lvl;
    logic [LEVEL_W-1:0] deq_lvl;
    logic [LEVEL_W-1:0] sel_lvl;
    logic [IW-1:0]      sel_head;
    logic [IW-1:0]      sel_tail;
    logic               sel_ne;
    logic [IW-1:0]      slot_idx;
    logic [AW-1:0]      base_addr;
    logic [AW-1:0]      ram_addr;
    logic               wr_en;
    logic               rd_en;
    logic [ENTRY_W-1:0] rd_data;
    logic [STATUS_W-1:0] exec_status;
    logic               is_deq;
    logic               any_ne;

    // Item register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command <= i_command;
            r_id      <= i_in_id;
            r_prio    <= i_in_priority;
        end
    end

    // Queue selection
    assign is_deq = (r_command == CMD_DEQ);
    assign any_ne = |r_nonempty;

    always_comb begin
        if (r_prio == PRIO_ONE) begin
            enq_lvl = LVL_ONE;
        end else if (r_prio == PRIO_TWO) begin
            enq_lvl = LVL_TWO;
        end else begin
            enq_lvl = LVL_THREE;
        end
        if (r_nonempty[0]) begin
            deq_lvl = LVL_ONE;
        end else if (r_nonempty[1]) begin
            deq_lvl = LVL_TWO;
        end else begin
            deq_lvl = LVL_THREE;
        end
    end

    assign sel_lvl  = is_deq ? deq_lvl : enq_lvl;
    assign sel_head = r_head[sel_lvl];
    assign sel_tail = r_tail[sel_lvl];
    assign sel_ne   = r_nonempty[sel_lvl];

    assign o_stat.deq_read = is_deq && any_ne;

    // Operation: index updates, RAM slot and status
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_nonempty  = r_nonempty;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        slot_idx    = '0;
        exec_status = ST_ENQUEUED;
        if (i_cmd.exec) begin
            if (!is_deq) begin
                if (!sel_ne) begin
                    // empty queue: restart at slot zero
                    n_head[sel_lvl]     = '0;
                    n_tail[sel_lvl]     = '0;
                    n_nonempty[sel_lvl] = 1'b1;
                    wr_en               = 1'b1;
                    slot_idx            = '0;
                end else if (sel_tail == IDX_LAST) begin
                    exec_status = ST_FULL;
                end else begin
                    n_tail[sel_lvl] = sel_tail + 1'b1;
                    wr_en           = 1'b1;
                    slot_idx        = sel_tail + 1'b1;
                end
            end else if (!any_ne) begin
                exec_status = ST_EMPTY;
            end else begin
                exec_status = ST_DEQUEUED;
                rd_en       = 1'b1;
                slot_idx    = sel_head;
                if (sel_head >= sel_tail) begin
                    // last job gone: queue drains and rewinds
                    n_head[sel_lvl]     = '0;
                    n_tail[sel_lvl]     = '0;
                    n_nonempty[sel_lvl] = 1'b0;
                end else begin
                    n_head[sel_lvl] = sel_head + 1'b1;
                end
            end
        end
    end

    // RAM address: queue base plus slot
    always_comb begin
        case (sel_lvl)
            LVL_ONE:   base_addr = '0;
            LVL_TWO:   base_addr = BASE_TWO;
            default:   base_addr = BASE_THREE;
        endcase
    end
    assign ram_addr = base_addr + AW'(slot_idx);

    tlpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (ram_addr),
        .i_wr_data ({r_id, r_prio}),
        .i_rd_en   (rd_en),
        .i_rd_addr (ram_addr),
        .o_rd_data (rd_data)
    );

    // Index state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_head[l] <= '0;
                r_tail[l] <= '0;
            end
            r_nonempty <= '0;
        end else begin
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_nonempty <= n_nonempty;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status    <= exec_status;
            r_out_id    <= '0;
            r_out_prio  <= '0;
            r_out_level <= (is_deq && !any_ne) ? LVL_ONE : sel_lvl;
        end else if (i_cmd.capture) begin
            r_out_id   <= rd_data[ENTRY_W-1:PRIO_W];
            r_out_prio <= rd_data[PRIO_W-1:0];
        end
    end

    assign o_status       = r_status;
    assign o_out_id       = r_out_id;
    assign o_out_priority = r_out_prio;
    assign o_out_level    = r_out_level;

endmodule

`default_nettype wire
